/* design/usbsrh_pkg.sv */
// Package for the USB standard request handler.
// Holds request codes, reply codes, register indexes and the result word type.
// No dependencies.
`default_nettype none

package usbsrh_pkg;

    // Standard bRequest codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    // Feature selector
    localparam logic [15:0] FEAT_REMOTE_WAKEUP = 16'd1;

    // Descriptor types (high byte of wValue)
    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    // Reply actions
    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_STATUS = 2'd1;
    localparam logic [1:0] ACT_STALL  = 2'd2;

    // Data sources
    localparam logic [2:0] SRC_NONE   = 3'd0;
    localparam logic [2:0] SRC_DEVICE = 3'd1;
    localparam logic [2:0] SRC_CONFIG = 3'd2;
    localparam logic [2:0] SRC_STRING = 3'd3;
    localparam logic [2:0] SRC_IMM    = 3'd4;

    // Fixed lengths of immediate replies
    localparam logic [15:0] LEN_STATUS_WORD = 16'd2;
    localparam logic [15:0] LEN_ONE_BYTE    = 16'd1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_DESC_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIG_TOTAL_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRING_LENGTHS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_STATUS    = 3'd4;
    localparam int unsigned CFG_DATA_W = 64;

    // Reset values of configuration registers
    localparam logic [7:0] DEVICE_DESC_LEN_RST = 8'd18;

    // Default number of string descriptor slots
    localparam int unsigned MAX_STRINGS_DEF = 8;

    // One result word
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  source;
        logic [2:0]  string_index;
        logic [15:0] immediate_data;
        logic [15:0] send_length;
        logic        address_write;
        logic [6:0]  device_address;
        logic        remote_wakeup_enabled;
    } result_t;

endpackage

`default_nettype wire

/* design/usb_standard_request_handler_unit.sv */
// Flow: a request word is taken into the input register, then moves to the result register
// once that register is free; its reply word is offered from the result register.
// Throughput: one request per cycle; while a reply waits, the input register takes one
// more word and then in_ready drops until the reply is taken.
// Reset (rst_n low, asynchronous): address, configuration, alternate setting and
// wakeup flag cleared; descriptor lengths and status restored to defaults.
`default_nettype none

module usb_standard_request_handler_unit #(
    parameter int unsigned MAX_STRINGS = usbsrh_pkg::MAX_STRINGS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // request channel
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [7:0]                        request_code,
    input  wire  [15:0]                       request_value,
    input  wire  [15:0]                       requested_length,
    // reply channel
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [1:0]                        action,
    output logic [2:0]                        source,
    output logic [2:0]                        string_index,
    output logic [15:0]                       immediate_data,
    output logic [15:0]                       send_length,
    output logic                              address_write,
    output logic [6:0]                        device_address,
    output logic                              remote_wakeup_enabled,
    // configuration write channel
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [usbsrh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [usbsrh_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] MAX_STR_CNT = 4'(MAX_STRINGS);

    // Configuration registers
    logic [7:0]  dev_desc_len_reg;
    logic [15:0] cfg_total_len_reg;
    logic [3:0]  str_count_reg;
    logic [7:0]  str_len_reg [MAX_STRINGS];
    logic [15:0] dev_status_reg;

    // Device state
    logic [6:0]  addr_reg,        addr_next;
    logic [7:0]  cfg_value_reg,   cfg_value_next;
    logic [7:0]  alt_setting_reg, alt_setting_next;
    logic        wakeup_reg,      wakeup_next;

    // Input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_code_reg;
    logic [15:0] s1_value_reg;
    logic [15:0] s1_wlen_reg;

    // Output stage
    logic        out_valid_reg;
    usbsrh_pkg::result_t res_reg, res_next;

    logic        out_free;
    logic        s1_advance;

    // Decode helpers
    logic [7:0]  desc_type;
    logic [7:0]  desc_idx;
    logic [3:0]  str_cnt_eff;
    logic [7:0]  str_len_sel;
    logic [2:0]  desc_src;
    logic [15:0] desc_len;

    // Handshake
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_desc_len_reg  <= usbsrh_pkg::DEVICE_DESC_LEN_RST;
            cfg_total_len_reg <= '0;
            str_count_reg     <= '0;
            dev_status_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                usbsrh_pkg::CFG_DEVICE_DESC_LEN:  dev_desc_len_reg  <= cfg_data[7:0];
                usbsrh_pkg::CFG_CONFIG_TOTAL_LEN: cfg_total_len_reg <= cfg_data[15:0];
                usbsrh_pkg::CFG_STRING_COUNT:     str_count_reg     <= cfg_data[3:0];
                usbsrh_pkg::CFG_DEVICE_STATUS:    dev_status_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // String length bytes, one slot per supported string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STRINGS; i++)
                str_len_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready && cfg_index == usbsrh_pkg::CFG_STRING_LENGTHS)
        begin
            for (int i = 0; i < MAX_STRINGS; i++)
                str_len_reg[i] <= cfg_data[i*8 +: 8];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_code_reg  <= request_code;
            s1_value_reg <= request_value;
            s1_wlen_reg  <= requested_length;
        end
    end

    // Descriptor lookup
    assign desc_type   = s1_value_reg[15:8];
    assign desc_idx    = s1_value_reg[7:0];
    assign str_cnt_eff = (str_count_reg > MAX_STR_CNT) ? MAX_STR_CNT : str_count_reg;

    always_comb
    begin
        str_len_sel = '0;
        for (int i = 0; i < MAX_STRINGS; i++)
        begin
            if (desc_idx == 8'(i))
                str_len_sel = str_len_reg[i];
        end
    end

    always_comb
    begin
        desc_src = usbsrh_pkg::SRC_NONE;
        desc_len = '0;
        priority if (desc_type == usbsrh_pkg::DT_DEVICE)
        begin
            desc_src = usbsrh_pkg::SRC_DEVICE;
            desc_len = {8'd0, dev_desc_len_reg};
        end
        else if (desc_type == usbsrh_pkg::DT_CONFIG)
        begin
            desc_src = usbsrh_pkg::SRC_CONFIG;
            desc_len = cfg_total_len_reg;
        end
        else if (desc_type == usbsrh_pkg::DT_STRING && desc_idx < {4'd0, str_cnt_eff})
        begin
            desc_src = usbsrh_pkg::SRC_STRING;
            desc_len = {8'd0, str_len_sel};
        end
        else
        begin
            desc_src = usbsrh_pkg::SRC_NONE;
        end
    end

    // Request decode and state update
    always_comb
    begin
        addr_next        = addr_reg;
        cfg_value_next   = cfg_value_reg;
        alt_setting_next = alt_setting_reg;
        wakeup_next      = wakeup_reg;
        res_next         = '0;
        res_next.action  = usbsrh_pkg::ACT_STALL;
        res_next.source  = usbsrh_pkg::SRC_NONE;

        unique case (s1_code_reg)
            usbsrh_pkg::REQ_GET_STATUS:
            begin
                res_next.action         = usbsrh_pkg::ACT_DATA;
                res_next.source         = usbsrh_pkg::SRC_IMM;
                res_next.immediate_data = dev_status_reg;
                res_next.send_length    = usbsrh_pkg::LEN_STATUS_WORD;
            end
            usbsrh_pkg::REQ_CLEAR_FEATURE,
            usbsrh_pkg::REQ_SET_FEATURE:
            begin
                // only the remote wakeup selector is honored
                if (s1_value_reg == usbsrh_pkg::FEAT_REMOTE_WAKEUP)
                begin
                    wakeup_next     = (s1_code_reg == usbsrh_pkg::REQ_SET_FEATURE);
                    res_next.action = usbsrh_pkg::ACT_STATUS;
                end
            end
            usbsrh_pkg::REQ_SET_ADDRESS:
            begin
                addr_next              = s1_value_reg[6:0];
                res_next.address_write = 1'b1;
                res_next.action        = usbsrh_pkg::ACT_STATUS;
            end
            usbsrh_pkg::REQ_GET_DESCRIPTOR:
            begin
                // absent or zero-length descriptor stalls; otherwise clamp to wLength
                if (desc_src != usbsrh_pkg::SRC_NONE && desc_len != '0)
                begin
                    res_next.action      = usbsrh_pkg::ACT_DATA;
                    res_next.source      = desc_src;
                    res_next.send_length = (s1_wlen_reg < desc_len) ? s1_wlen_reg : desc_len;
                    if (desc_src == usbsrh_pkg::SRC_STRING)
                        res_next.string_index = desc_idx[2:0];
                end
            end
            usbsrh_pkg::REQ_GET_CONFIGURATION:
            begin
                res_next.action         = usbsrh_pkg::ACT_DATA;
                res_next.source         = usbsrh_pkg::SRC_IMM;
                res_next.immediate_data = {8'd0, cfg_value_reg};
                res_next.send_length    = usbsrh_pkg::LEN_ONE_BYTE;
            end
            usbsrh_pkg::REQ_SET_CONFIGURATION:
            begin
                cfg_value_next  = s1_value_reg[7:0];
                res_next.action = usbsrh_pkg::ACT_STATUS;
            end
            usbsrh_pkg::REQ_GET_INTERFACE:
            begin
                res_next.action         = usbsrh_pkg::ACT_DATA;
                res_next.source         = usbsrh_pkg::SRC_IMM;
                res_next.immediate_data = {8'd0, alt_setting_reg};
                res_next.send_length    = usbsrh_pkg::LEN_ONE_BYTE;
            end
            usbsrh_pkg::REQ_SET_INTERFACE:
            begin
                alt_setting_next = s1_value_reg[7:0];
                res_next.action  = usbsrh_pkg::ACT_STATUS;
            end
            default: ;
        endcase

        res_next.device_address        = addr_next;
        res_next.remote_wakeup_enabled = wakeup_next;
    end

    // Device state registers, updated as each request leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg        <= '0;
            cfg_value_reg   <= '0;
            alt_setting_reg <= '0;
            wakeup_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            addr_reg        <= addr_next;
            cfg_value_reg   <= cfg_value_next;
            alt_setting_reg <= alt_setting_next;
            wakeup_reg      <= wakeup_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
            res_reg <= res_next;
    end

    assign out_valid             = out_valid_reg;
    assign action                = res_reg.action;
    assign source                = res_reg.source;
    assign string_index          = res_reg.string_index;
    assign immediate_data        = res_reg.immediate_data;
    assign send_length           = res_reg.send_length;
    assign address_write         = res_reg.address_write;
    assign device_address        = res_reg.device_address;
    assign remote_wakeup_enabled = res_reg.remote_wakeup_enabled;

    // Checks
    a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == usbsrh_pkg::ACT_STALL) |->
            (source == usbsrh_pkg::SRC_NONE && send_length == '0))
        else $error("stall reply carries data");

    a_addr_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && address_write) |-> (action == usbsrh_pkg::ACT_STATUS))
        else $error("address write without status reply");

    a_imm_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && source == usbsrh_pkg::SRC_IMM) |->
            (send_length == usbsrh_pkg::LEN_ONE_BYTE ||
             send_length == usbsrh_pkg::LEN_STATUS_WORD))
        else $error("immediate reply has wrong length");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are full");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(s1_advance) |-> ($stable(addr_reg) && $stable(wakeup_reg)))
        else $error("device state changed without a request");

endmodule

`default_nettype wire
